/* hw/rtl/b2da_pkg.sv */
// Shared types, constants and the BCD adjust function for the binary to decimal converter.
package b2da_pkg;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned NUM_DIGITS = 20;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int unsigned BITS_PER_STEP = 2;
  localparam int unsigned NUM_STEPS  = VALUE_W / BITS_PER_STEP;
  localparam int unsigned STEP_CNT_W = $clog2(NUM_STEPS);
  localparam int unsigned IDX_W      = $clog2(NUM_DIGITS);
  localparam int unsigned CHAR_W     = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_CONVERT = 5'b00010,
    S_SIZE    = 5'b00100,
    S_SIGN    = 5'b01000,
    S_DIGITS  = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic size;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic step_last;
    logic negative;
    logic out_free;
    logic idx_zero;
  } status_t;

  // One shift-and-add-3 step: adjust every digit of five or more, then shift in one bit.
  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b, input logic bit_in);
    logic [BCD_W-1:0] adj;
    adj = b;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (b[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        adj[d*DIGIT_W +: DIGIT_W] = b[d*DIGIT_W +: DIGIT_W] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

endpackage

/* hw/rtl/binary_to_decimal_ascii.sv */
// Top level: 64-bit integer to decimal ASCII text, one character per output transaction.
// An item passes an accept step, the conversion (shift-and-add-3, two bits per cycle), a sizing
// step, then emits its characters (1 to 20) one at a time as the output register frees up.
// The first character is registered after the sizing step, once the output register is free.
// A new item is taken once the last character sits in the output register.
// Reset clears the controller state and the output valid flag.
module binary_to_decimal_ascii
  import b2da_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] value,
  input  logic               is_signed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  character,
  output logic               last
);

  cmd_t    cmd;
  status_t status;

  b2da_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  b2da_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .value     (value),
    .is_signed (is_signed),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last)
  );

endmodule

/* hw/rtl/b2da_datapath.sv */
// Datapath: magnitude register, BCD accumulator, digit index and output register.
module b2da_datapath
  import b2da_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic [VALUE_W-1:0]  value,
  input  logic                is_signed,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHAR_W-1:0]   character,
  output logic                last
);

  logic [VALUE_W-1:0]    bin;
  logic [BCD_W-1:0]      bcd;
  logic                  neg;
  logic [STEP_CNT_W-1:0] step_cnt;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      top_idx;
  logic                  in_neg;
  logic [VALUE_W-1:0]    mag;
  logic [DIGIT_W-1:0]    digit;

  assign in_neg = is_signed & value[VALUE_W-1];
  assign mag    = in_neg ? (~value + 64'd1) : value;
  assign digit  = bcd[{idx, 2'b00} +: DIGIT_W];

  // Position of the most significant nonzero digit; zero gives position zero.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin      <= mag;
      bcd      <= '0;
      neg      <= in_neg;
      step_cnt <= '0;
    end else if (cmd.step) begin
      bin      <= {bin[VALUE_W-3:0], 2'b00};
      bcd      <= dabble(dabble(bcd, bin[VALUE_W-1]), bin[VALUE_W-2]);
      step_cnt <= step_cnt + 1'b1;
    end
    if (cmd.size) begin
      idx <= top_idx;
    end else if (cmd.emit_digit && idx != '0) begin
      idx <= idx - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      character <= ASCII_MINUS;
      last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      character <= {4'b0000, digit} + ASCII_ZERO;
      last      <= (idx == '0);
    end
  end

  assign status.step_last = (step_cnt == STEP_CNT_W'(NUM_STEPS - 1));
  assign status.negative  = neg;
  assign status.out_free  = !out_valid || out_ready;
  assign status.idx_zero  = (idx == '0);

endmodule

/* hw/rtl/b2da_ctrl.sv */
// Controller state machine that sequences load, conversion, sizing and character emission.
module b2da_ctrl
  import b2da_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CONVERT;
        end
      end
      S_CONVERT: begin
        cmd.step = 1'b1;
        if (status.step_last) begin
          state_next = S_SIZE;
        end
      end
      S_SIZE: begin
        cmd.size   = 1'b1;
        state_next = status.negative ? S_SIGN : S_DIGITS;
      end
      S_SIGN: begin
        if (status.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = S_DIGITS;
        end
      end
      S_DIGITS: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          if (status.idx_zero) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
